[sv/periodic_task_tick_scheduler_defines.svh]
// ---------------------------------------------------------------------------
// Periodic task tick scheduler assertion macros
// Shared property shorthands for the scheduler's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ptts_pkg.sv]
// ---------------------------------------------------------------------------
// Periodic task tick scheduler package
// Opcodes, field widths, controller states and the result record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptts_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned OPC_W       = 3;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned ENTRY_W     = 2 * CNT_W;
  // Only slots that a request can address are able to fire.
  localparam int unsigned FIRE_W      = 8;
  // Wide enough to hold any table size in the supported range.
  localparam int unsigned SLOT_EXT_W  = 7;
  localparam int unsigned TASK_SLOTS_DEF = 8;

  typedef enum logic [OPC_W-1:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_SUSPEND = 3'd2,
    OP_RESUME  = 3'd3,
    OP_KILL    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              fire_valid;
    logic [SLOT_W-1:0] fired_slot;
    logic              last_result;
  } res_t;

endpackage

[sv/ptts_table_mem.sv]
// ---------------------------------------------------------------------------
// Task table memory
// Synchronous single-write, single-read memory holding {reload, countdown}
// per task slot, with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_table_mem import ptts_pkg::*; #(
  parameter int unsigned DEPTH = TASK_SLOTS_DEF,
  parameter int unsigned AW    = 3
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem_r [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/ptts_out_reg.sv]
// ---------------------------------------------------------------------------
// Result output register
// One-entry output register that decouples the controller from a stalled
// receiver on the result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_out_reg import ptts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  res_t              push_data,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_fire_valid,
  output logic [SLOT_W-1:0] out_fired_slot,
  output logic              out_last_result
);

  logic vld_r;
  logic vld_nxt;
  res_t data_r;

  // The register can take a new result when empty or when it drains now.
  assign free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (push) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign out_valid       = vld_r;
  assign out_fire_valid  = data_r.fire_valid;
  assign out_fired_slot  = data_r.fired_slot;
  assign out_last_result = data_r.last_result;

endmodule

[sv/periodic_task_tick_scheduler.sv]
// ---------------------------------------------------------------------------
// Periodic task tick scheduler
// Time-triggered task table: create, suspend, resume and kill requests edit
// a slot, and a tick request walks the table and reports each slot that is
// due to run.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: opcode, task
//   slot, period and first delay. Result channel (out_valid/out_ready)
//   returns fire_valid, fired_slot and last_result.
//   Create, suspend, resume, kill and unused opcodes are handled straight
//   from idle and their single empty acknowledgement appears in the next cycle.
//   A tick reads the task table memory one slot per cycle, writing each
//   slot back after its read; the fired slots then follow one per cycle
//   while the output register has free space.
//   One request is in work at a time; the next one is taken once the last
//   result of the previous one has been pushed and the output register is free.
//   Reset clears all present and ready flags at once, which makes every
//   slot inert; countdown and period entries are rewritten by create before
//   they are ever used, so no clearing pass is needed.
//   A stalled receiver holds the output register; the walk itself never
//   stalls, and results then wait one per cycle of free output space.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_task_tick_scheduler_defines.svh"

module periodic_task_tick_scheduler import ptts_pkg::*; #(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [SLOT_W-1:0] in_task_slot,
  input  logic [CNT_W-1:0]  in_period,
  input  logic [CNT_W-1:0]  in_first_delay,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_fire_valid,
  output logic [SLOT_W-1:0] out_fired_slot,
  output logic              out_last_result
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);

  state_t                state_r, state_nxt;
  logic [CW-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic                  b_vld_r, b_vld_nxt;
  logic [IW-1:0]         b_idx_r, b_idx_nxt;
  logic [FIRE_W-1:0]     fire_mask_r, fire_mask_nxt;
  logic [TASK_SLOTS-1:0] present_r, present_nxt;
  logic [TASK_SLOTS-1:0] ready_r, ready_nxt;

  logic                  accept;
  logic                  out_free;
  logic                  push;
  res_t                  push_data;
  op_t                   op;
  logic [SLOT_EXT_W-1:0] slot_ext;
  logic                  slot_ok;
  logic [IW-1:0]         slot_idx;

  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic                  mem_re;
  logic [IW-1:0]         mem_raddr;
  logic [ENTRY_W-1:0]    mem_rdata;
  logic [CNT_W-1:0]      rd_reload;
  logic [CNT_W-1:0]      rd_count;

  logic [FIRE_W-1:0]     low_bit;
  logic [SLOT_W-1:0]     low_slot;
  logic [FIRE_W-1:0]     mask_left;

  // Request decode.
  assign op       = op_t'(in_opcode);
  assign slot_ext = {{(SLOT_EXT_W - SLOT_W){1'b0}}, in_task_slot};
  assign slot_ok  = slot_ext < SLOT_EXT_W'(TASK_SLOTS);
  assign slot_idx = slot_ext[IW-1:0];
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign rd_reload = mem_rdata[ENTRY_W-1:CNT_W];
  assign rd_count  = mem_rdata[CNT_W-1:0];

  // Lowest pending fired slot.
  always_comb begin
    low_slot = '0;
    for (int i = FIRE_W - 1; i >= 0; i--) begin
      if (fire_mask_r[i]) begin
        low_slot = SLOT_W'(i);
      end
    end
    low_bit   = FIRE_W'(1) << low_slot;
    mask_left = fire_mask_r & ~low_bit;
  end

  // Controller: request handling, table walk and result emission.
  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    b_vld_nxt     = 1'b0;
    b_idx_nxt     = b_idx_r;
    fire_mask_nxt = fire_mask_r;
    present_nxt   = present_r;
    ready_nxt     = ready_r;
    push          = 1'b0;
    push_data     = '{fire_valid: 1'b0, fired_slot: '0, last_result: 1'b1};
    mem_we        = 1'b0;
    mem_waddr     = slot_idx;
    mem_wdata     = {in_period, in_first_delay};
    mem_re        = 1'b0;
    mem_raddr     = rd_cnt_r[IW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_TICK) begin
            state_nxt     = ST_WALK;
            rd_cnt_nxt    = '0;
            fire_mask_nxt = '0;
          end else begin
            push = 1'b1;
            if (slot_ok) begin
              case (op)
                OP_CREATE: begin
                  mem_we                = 1'b1;
                  present_nxt[slot_idx] = 1'b1;
                  ready_nxt[slot_idx]   = 1'b1;
                end
                OP_SUSPEND: ready_nxt[slot_idx]   = 1'b0;
                OP_RESUME:  ready_nxt[slot_idx]   = 1'b1;
                OP_KILL:    present_nxt[slot_idx] = 1'b0;
                default: ;
              endcase
            end
          end
        end
      end

      ST_WALK: begin
        // Read side: issue the next slot while one remains.
        if (rd_cnt_r != CW'(TASK_SLOTS)) begin
          mem_re     = 1'b1;
          rd_cnt_nxt = rd_cnt_r + CW'(1);
          b_vld_nxt  = 1'b1;
          b_idx_nxt  = rd_cnt_r[IW-1:0];
        end else begin
          state_nxt = ST_EMIT;
        end
        // Update side: count down or reload the slot read last cycle.
        if (b_vld_r && present_r[b_idx_r] && ready_r[b_idx_r]) begin
          mem_we    = 1'b1;
          mem_waddr = b_idx_r;
          if (rd_count == '0) begin
            mem_wdata     = {rd_reload, CNT_W'(rd_reload - CNT_W'(1))};
            fire_mask_nxt = fire_mask_r | (FIRE_W'(1) << b_idx_r);
          end else begin
            mem_wdata = {rd_reload, CNT_W'(rd_count - CNT_W'(1))};
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          push = 1'b1;
          if (fire_mask_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            push_data = '{fire_valid: 1'b1, fired_slot: low_slot,
                          last_result: (mask_left == '0)};
            fire_mask_nxt = mask_left;
            if (mask_left == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      b_vld_r     <= 1'b0;
      fire_mask_r <= '0;
      present_r   <= '0;
      ready_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      b_vld_r     <= b_vld_nxt;
      fire_mask_r <= fire_mask_nxt;
      present_r   <= present_nxt;
      ready_r     <= ready_nxt;
    end
  end

  // Slot index of the pending update carries no reset.
  always_ff @(posedge clk) begin
    b_idx_r <= b_idx_nxt;
  end

  ptts_table_mem #(
    .DEPTH (TASK_SLOTS),
    .AW    (IW)
  ) u_table_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ptts_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .push_data       (push_data),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_fire_valid  (out_fire_valid),
    .out_fired_slot  (out_fired_slot),
    .out_last_result (out_last_result)
  );

  // Results are only pushed into free output space.
  `PTTS_ASSERT_IMP(a_push_free, clk, rst_n, push, out_free, "result pushed into full register")
  // A tick request starts the walk at slot zero.
  `PTTS_ASSERT_NXT(a_tick_walk, clk, rst_n, accept && (op == OP_TICK),
    (state_r == ST_WALK) && (rd_cnt_r == '0), "tick did not start walk")
  // The read and the write-back of one cycle never address the same slot.
  `PTTS_ASSERT_IMP(a_no_overlap, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr,
    "table read and write overlap")
  // An empty emission ends the tick.
  `PTTS_ASSERT_NXT(a_empty_end, clk, rst_n,
    (state_r == ST_EMIT) && (fire_mask_r == '0) && out_free,
    state_r == ST_IDLE, "empty tick result did not finish")

endmodule

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// Periodic task tick scheduler testbench
// Sends create, suspend, resume, kill, tick and spare-opcode requests with
// random gaps on both channels. A scoreboard keeps its own copy of the task
// table, predicts every result in order and checks each one field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import ptts_pkg::*; ();

  localparam int SLOTS          = TASK_SLOTS_DEF;
  localparam int RANDOM_REQS    = 133;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_PRINTED    = 30;
  // Opcodes 5 to 7 have no operation behind them.
  localparam logic [OPC_W-1:0] OPC_SPARE_FIRST = 3'd5;
  localparam logic [OPC_W-1:0] OPC_SPARE_LAST  = 3'd7;

  // Scoreboard: mirror of the task table and the queue of due results.
  class sched_scoreboard;
    logic [CNT_W-1:0] delay_left [SLOTS];
    logic [CNT_W-1:0] reload     [SLOTS];
    bit               ready      [SLOTS];
    bit               present    [SLOTS];
    res_t             due_results[$];
    int               mismatches;
    int               requests;
    int               ticks;
    int               fires;
    int               most_fires;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        delay_left[i] = '0;
        reload[i]     = '0;
        ready[i]      = 1'b0;
        present[i]    = 1'b0;
      end
    endfunction

    // Apply one accepted request to the table and queue its results.
    function void note_request(logic [OPC_W-1:0] opc, logic [SLOT_W-1:0] slot,
                               logic [CNT_W-1:0] per, logic [CNT_W-1:0] dly);
      res_t fired[$];
      res_t ack;
      ack = '{fire_valid: 1'b0, fired_slot: '0, last_result: 1'b1};
      requests++;
      case (opc)
        OP_TICK: begin
          ticks++;
          for (int i = 0; i < SLOTS; i++) begin
            if (present[i] && ready[i]) begin
              if (delay_left[i] == '0) begin
                delay_left[i] = reload[i] - 1'b1;
                fired.push_back('{fire_valid: 1'b1, fired_slot: SLOT_W'(i),
                                  last_result: 1'b0});
              end else begin
                delay_left[i] = delay_left[i] - 1'b1;
              end
            end
          end
          if (fired.size() == 0) begin
            due_results.push_back(ack);
          end else begin
            fired[fired.size() - 1].last_result = 1'b1;
            fires += fired.size();
            if (fired.size() > most_fires) most_fires = fired.size();
            foreach (fired[k]) due_results.push_back(fired[k]);
          end
        end
        OP_CREATE: begin
          reload[slot]     = per;
          delay_left[slot] = dly;
          ready[slot]      = 1'b1;
          present[slot]    = 1'b1;
          due_results.push_back(ack);
        end
        OP_SUSPEND: begin
          ready[slot] = 1'b0;
          due_results.push_back(ack);
        end
        OP_RESUME: begin
          ready[slot] = 1'b1;
          due_results.push_back(ack);
        end
        OP_KILL: begin
          present[slot] = 1'b0;
          due_results.push_back(ack);
        end
        default: begin
          due_results.push_back(ack);
        end
      endcase
    endfunction

    // Print one line per mismatch; printing stops after a while, counting does not.
    task report_mismatch(string what);
      if (mismatches < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    // Compare an accepted result with the oldest due one.
    task check_result(logic fire_valid, logic [SLOT_W-1:0] fired_slot,
                      logic last_result);
      res_t due;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result fire_valid=%0b slot=%0d last=%0b",
                                  fire_valid, fired_slot, last_result));
        return;
      end
      due = due_results.pop_front();
      if (fire_valid !== due.fire_valid)
        report_mismatch($sformatf("fire_valid %0b, due %0b", fire_valid, due.fire_valid));
      if (fired_slot !== due.fired_slot)
        report_mismatch($sformatf("fired_slot %0d, due %0d", fired_slot, due.fired_slot));
      if (last_result !== due.last_result)
        report_mismatch($sformatf("last_result %0b, due %0b", last_result,
                                  due.last_result));
    endtask

    function int pending();
      return due_results.size();
    endfunction

    // Anything still queued at the end never arrived.
    task flush_leftovers();
      while (due_results.size() != 0) begin
        void'(due_results.pop_front());
        report_mismatch("due result never arrived");
      end
    endtask
  endclass

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [OPC_W-1:0]  in_opcode      = '0;
  logic [SLOT_W-1:0] in_task_slot   = '0;
  logic [CNT_W-1:0]  in_period      = '0;
  logic [CNT_W-1:0]  in_first_delay = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic              out_fire_valid;
  logic [SLOT_W-1:0] out_fired_slot;
  logic              out_last_result;

  sched_scoreboard sb = new();
  bit              stall_free = 1'b0;
  int              cycles     = 0;

  periodic_task_tick_scheduler #(.TASK_SLOTS(SLOTS)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_task_slot   (in_task_slot),
    .in_period      (in_period),
    .in_first_delay (in_first_delay),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_fire_valid (out_fire_valid),
    .out_fired_slot (out_fired_slot),
    .out_last_result(out_last_result)
  );

  always #2 clk = ~clk;

  // Watch both channels at every edge once reset is released.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_request(in_opcode, in_task_slot, in_period, in_first_delay);
      if (out_valid && out_ready)
        sb.check_result(out_fire_valid, out_fired_slot, out_last_result);
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: a random stall before taking each result.
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = stall_free ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one request after a random gap and hold it until it is taken.
  task automatic send_request(input logic [OPC_W-1:0] opc, input logic [SLOT_W-1:0] slot,
                              input logic [CNT_W-1:0] per, input logic [CNT_W-1:0] dly);
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= opc;
    in_task_slot   <= slot;
    in_period      <= per;
    in_first_delay <= dly;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off new requests until every due result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random request, biased toward small periods and delays so slots fire often.
  task automatic send_random_request();
    int               pick;
    logic [OPC_W-1:0] opc;
    logic [CNT_W-1:0] per;
    logic [CNT_W-1:0] dly;
    pick = $urandom_range(0, 99);
    per  = CNT_W'($urandom);
    dly  = CNT_W'($urandom);
    if (pick < 45) begin
      opc = OP_TICK;
    end else if (pick < 70) begin
      opc = OP_CREATE;
      if ($urandom_range(0, 4) != 0) per = CNT_W'($urandom_range(0, 4));
      if ($urandom_range(0, 4) != 0) dly = CNT_W'($urandom_range(0, 5));
    end else if (pick < 80) begin
      opc = OP_SUSPEND;
    end else if (pick < 90) begin
      opc = OP_RESUME;
    end else if (pick < 97) begin
      opc = OP_KILL;
    end else begin
      opc = OPC_SPARE_FIRST + OPC_W'($urandom_range(0, OPC_SPARE_LAST - OPC_SPARE_FIRST));
    end
    send_request(opc, SLOT_W'($urandom_range(0, SLOTS - 1)), per, dly);
  endtask

  // Reset, directed requests, random requests, then the final check.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, then a zero period that wraps on reload.
    send_request(OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_request(OP_CREATE, 3'd0, 16'h0000, 16'h0000);
    send_request(OP_TICK, 3'd0, 16'hFFFF, 16'hFFFF);
    send_request(OP_TICK, 3'd0, 16'h0000, 16'h0000);
    // Largest period and delay, plus two fast slots.
    send_request(OP_CREATE, 3'd7, 16'hFFFF, 16'hFFFF);
    send_request(OP_CREATE, 3'd3, 16'h0001, 16'h0000);
    send_request(OP_CREATE, 3'd5, 16'h0002, 16'h0001);
    send_request(OP_TICK, 3'd7, 16'h0000, 16'h0000);
    send_request(OP_TICK, 3'd0, 16'h0000, 16'h0000);
    // Suspend and resume, kill, and resume of a slot that was never created.
    send_request(OP_SUSPEND, 3'd3, 16'h0000, 16'h0000);
    send_request(OP_TICK, 3'd0, 16'h0000, 16'h0000);
    send_request(OP_RESUME, 3'd3, 16'h0000, 16'h0000);
    send_request(OP_KILL, 3'd5, 16'h0000, 16'h0000);
    send_request(OP_RESUME, 3'd6, 16'h0000, 16'h0000);
    send_request(OP_TICK, 3'd0, 16'h0000, 16'h0000);
    // Spare opcodes leave the table alone.
    send_request(OPC_SPARE_FIRST, 3'd2, 16'hA5A5, 16'h5A5A);
    send_request(OPC_SPARE_FIRST + 3'd1, 3'd4, 16'h5A5A, 16'hA5A5);
    send_request(OPC_SPARE_LAST, 3'd1, 16'hFFFF, 16'h0000);
    // Every slot due on the same tick.
    for (int i = 0; i < SLOTS; i++)
      send_request(OP_CREATE, SLOT_W'(i), 16'h0001, 16'h0000);
    send_request(OP_TICK, 3'd0, 16'h0000, 16'h0000);
    drain_results();

    for (int k = 0; k < RANDOM_REQS; k++) begin
      stall_free = (k >= 60 && k < 85);
      if (k == 40 || k == 110) drain_results();
      send_random_request();
    end
    drain_results();
    repeat (4 * SLOTS) @(posedge clk);
    sb.flush_leftovers();

    $display("Ran %0d requests: %0d ticks, %0d slot firings, up to %0d on one tick.",
             sb.requests, sb.ticks, sb.fires, sb.most_fires);
    $display("Both channels stalled at random, with one stretch of back-to-back traffic.");
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[periodic_task_tick_scheduler.f]
+incdir+sv
sv/ptts_pkg.sv
sv/ptts_table_mem.sv
sv/ptts_out_reg.sv
sv/periodic_task_tick_scheduler.sv
bench/tb_top.sv
